/* rtl/shc_pkg.sv */
package shc_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    // Reduction works on Q.30 angles of up to eight radians.
    localparam int RW = 36;
    // CORDIC datapath width for x, y and the residual angle.
    localparam int XW = 34;
    localparam int ZW = 34;
    // Width handed to the 16-bit saturation helper.
    localparam int SATW = XW + 1;

    localparam logic signed [RW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [RW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [RW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;

    localparam logic [2:0] REG_SPEED_TARGET   = 3'd0;
    localparam logic [2:0] REG_HEADING_TARGET = 3'd1;
    localparam logic [2:0] REG_SURGE_GAIN     = 3'd2;
    localparam logic [2:0] REG_THRUST_LIMIT   = 3'd3;
    localparam logic [2:0] REG_YAW_PROP_GAIN  = 3'd4;
    localparam logic [2:0] REG_YAW_DAMP_GAIN  = 3'd5;
    localparam logic [2:0] REG_MOMENT_LIMIT   = 3'd6;
    localparam logic [2:0] REG_HOLD_TIME_MS   = 3'd7;

    // Values carried beside the angle through reduction and rotation.
    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vl;
        logic signed [15:0] rate;
        logic signed [16:0] herr;
        logic               hold;
        logic               neg;
    } side_t;

    typedef struct packed {
        logic signed [15:0] speed_target;
        logic [15:0]        surge_gain;
        logic [15:0]        thrust_limit;
        logic [15:0]        yaw_prop_gain;
        logic [15:0]        yaw_damp_gain;
        logic [15:0]        moment_limit;
    } law_cfg_t;

    // round(atan(2^-i) * 2^30); stages past the table rotate by zero.
    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] a;
        case (idx)
            0:       a = 32'd843314857;
            1:       a = 32'd497837829;
            2:       a = 32'd263043837;
            3:       a = 32'd133525159;
            4:       a = 32'd67021687;
            5:       a = 32'd33543516;
            6:       a = 32'd16775851;
            7:       a = 32'd8388437;
            8:       a = 32'd4194283;
            9:       a = 32'd2097149;
            10:      a = 32'd1048576;
            11:      a = 32'd524288;
            12:      a = 32'd262144;
            13:      a = 32'd131072;
            14:      a = 32'd65536;
            15:      a = 32'd32768;
            16:      a = 32'd16384;
            17:      a = 32'd8192;
            18:      a = 32'd4096;
            19:      a = 32'd2048;
            20:      a = 32'd1024;
            21:      a = 32'd512;
            22:      a = 32'd256;
            23:      a = 32'd128;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [SATW-1:0] v);
        logic signed [15:0] r;
        if (v > $signed(SATW'(32767)))
        begin
            r = 16'sd32767;
        end
        else if (v < -$signed(SATW'(32768)))
        begin
            r = -16'sd32768;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* rtl/shc_reduce.sv */
module shc_reduce
    import shc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [15:0]   heading,
    input  side_t                side_in,
    output logic                 out_valid,
    output logic signed [ZW-1:0] z_out,
    output side_t                side_out
);

    logic signed [RW-1:0] z0;
    logic signed [RW-1:0] wrap_next;
    logic signed [RW-1:0] wrap_reg;
    logic                 vld1_reg;
    side_t                side1_reg;
    logic signed [RW-1:0] fold_next;
    logic                 neg_next;
    logic signed [ZW-1:0] z2_reg;
    logic                 vld2_reg;
    side_t                side2_reg;
    side_t                side2_next;

    // The heading spans at most eight radians, so one turn of correction
    // always lands in [-pi, pi].
    always_comb
    begin
        z0 = $signed({{(RW-34){heading[15]}}, heading, 18'b0});
        if (z0 > PI_Q30)
        begin
            wrap_next = z0 - TWO_PI_Q30;
        end
        else if (z0 < -PI_Q30)
        begin
            wrap_next = z0 + TWO_PI_Q30;
        end
        else
        begin
            wrap_next = z0;
        end
    end

    // Fold into the right half plane; the rotated vector is negated later.
    always_comb
    begin
        side2_next = side1_reg;
        neg_next   = 1'b0;
        fold_next  = wrap_reg;
        if (wrap_reg > HALF_PI_Q30)
        begin
            fold_next = wrap_reg - PI_Q30;
            neg_next  = 1'b1;
        end
        else if (wrap_reg < -HALF_PI_Q30)
        begin
            fold_next = wrap_reg + PI_Q30;
            neg_next  = 1'b1;
        end
        side2_next.neg = neg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wrap_reg  <= wrap_next;
            side1_reg <= side_in;
            z2_reg    <= fold_next[ZW-1:0];
            side2_reg <= side2_next;
        end
    end

    assign out_valid = vld2_reg;
    assign z_out     = z2_reg;
    assign side_out  = side2_reg;

endmodule

/* rtl/shc_cordic.sv */
module shc_cordic
    import shc_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [ZW-1:0] z_in,
    input  side_t                side_in,
    output logic                 out_valid,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output side_t                side_out
);

    logic signed [XW-1:0] xs_in  [STAGES];
    logic signed [XW-1:0] ys_in  [STAGES];
    logic signed [ZW-1:0] zs_in  [STAGES];
    side_t                sd_in  [STAGES];
    logic [STAGES-1:0]    vs_in;
    logic signed [XW-1:0] x_reg  [STAGES];
    logic signed [XW-1:0] y_reg  [STAGES];
    logic signed [ZW-1:0] z_reg  [STAGES];
    side_t                sd_reg [STAGES];
    logic [STAGES-1:0]    vld_reg;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam logic [31:0] ATAN_RAW = atan_q30(k);
        localparam logic signed [ZW-1:0] ATAN_K = $signed({{(ZW-32){1'b0}}, ATAN_RAW});

        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        if (k == 0)
        begin : g_first
            assign xs_in[k] = GAIN_Q30;
            assign ys_in[k] = '0;
            assign zs_in[k] = z_in;
            assign sd_in[k] = side_in;
            assign vs_in[k] = in_valid;
        end
        else
        begin : g_next
            assign xs_in[k] = x_reg[k-1];
            assign ys_in[k] = y_reg[k-1];
            assign zs_in[k] = z_reg[k-1];
            assign sd_in[k] = sd_reg[k-1];
            assign vs_in[k] = vld_reg[k-1];
        end

        always_comb
        begin
            if (zs_in[k] >= 0)
            begin
                x_next = xs_in[k] - (ys_in[k] >>> k);
                y_next = ys_in[k] + (xs_in[k] >>> k);
                z_next = zs_in[k] - ATAN_K;
            end
            else
            begin
                x_next = xs_in[k] + (ys_in[k] >>> k);
                y_next = ys_in[k] - (xs_in[k] >>> k);
                z_next = zs_in[k] + ATAN_K;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vs_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]  <= x_next;
                y_reg[k]  <= y_next;
                z_reg[k]  <= z_next;
                sd_reg[k] <= sd_in[k];
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign x_out     = x_reg[STAGES-1];
    assign y_out     = y_reg[STAGES-1];
    assign side_out  = sd_reg[STAGES-1];

endmodule

/* rtl/shc_law.sv */
module shc_law
    import shc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  side_t                side_in,
    input  law_cfg_t             cfg,
    output logic                 out_valid,
    output logic signed [16:0]   thrust,
    output logic signed [16:0]   turn_moment,
    output logic signed [15:0]   forward_speed,
    output logic                 holding
);

    localparam logic signed [XW:0] RND_POS = (XW+1)'(16384);
    localparam logic signed [XW:0] RND_NEG = (XW+1)'(16385);

    // Round stage: cos and sin to Q1.15.
    logic signed [XW:0]   xe;
    logic signed [XW:0]   ye;
    logic signed [XW:0]   xr;
    logic signed [XW:0]   yr;
    logic signed [XW:0]   xsh;
    logic signed [XW:0]   ysh;
    logic signed [15:0]   cos_reg;
    logic signed [15:0]   sin_reg;
    side_t                sdr_reg;
    logic                 vr_reg;

    // Product stage.
    logic signed [31:0]   pv_reg;
    logic signed [31:0]   ps_reg;
    logic signed [33:0]   pm_reg;
    logic signed [32:0]   pd_reg;
    logic                 hold1_reg;
    logic                 v1_reg;
    logic signed [31:0]   pv_next;
    logic signed [31:0]   ps_next;
    logic signed [33:0]   pm_next;
    logic signed [32:0]   pd_next;

    // Projection and moment stage.
    logic signed [32:0]   pdiff;
    logic signed [32:0]   pdiff_sh;
    logic signed [34:0]   mdiff;
    logic signed [34:0]   mdiff_sh;
    logic signed [34:0]   mlim;
    logic signed [15:0]   u_next;
    logic signed [16:0]   mom_next;
    logic signed [15:0]   u2_reg;
    logic signed [16:0]   mom2_reg;
    logic                 hold2_reg;
    logic                 v2_reg;

    // Speed error stage.
    logic signed [16:0]   serr_reg;
    logic signed [15:0]   u3_reg;
    logic signed [16:0]   mom3_reg;
    logic                 hold3_reg;
    logic                 v3_reg;

    // Thrust product stage.
    logic signed [33:0]   tp_reg;
    logic signed [33:0]   tp_next;
    logic signed [15:0]   u4_reg;
    logic signed [16:0]   mom4_reg;
    logic                 hold4_reg;
    logic                 v4_reg;

    // Output stage.
    logic signed [33:0]   tsh;
    logic signed [33:0]   tlim;
    logic signed [16:0]   thr_next;
    logic signed [16:0]   thr_reg;
    logic signed [16:0]   mom5_reg;
    logic signed [15:0]   u5_reg;
    logic                 hold5_reg;
    logic                 v5_reg;

    // Negation folds into the rounding add: -v + r equals ~v + r + 1.
    always_comb
    begin
        xe = $signed({x_in[XW-1], x_in});
        ye = $signed({y_in[XW-1], y_in});
        if (side_in.neg)
        begin
            xr = ~xe + RND_NEG;
            yr = ~ye + RND_NEG;
        end
        else
        begin
            xr = xe + RND_POS;
            yr = ye + RND_POS;
        end
        xsh = xr >>> 15;
        ysh = yr >>> 15;
    end

    always_comb
    begin
        pv_next = sdr_reg.vx * cos_reg;
        ps_next = sdr_reg.vl * sin_reg;
        pm_next = $signed({1'b0, cfg.yaw_prop_gain}) * sdr_reg.herr;
        pd_next = $signed({1'b0, cfg.yaw_damp_gain}) * sdr_reg.rate;
    end

    always_comb
    begin
        pdiff    = pv_reg - ps_reg;
        pdiff_sh = pdiff >>> 15;
        u_next   = sat16($signed({{(SATW-33){pdiff_sh[32]}}, pdiff_sh}));
        mdiff    = pm_reg - pd_reg;
        mdiff_sh = mdiff >>> 12;
        mlim     = $signed({19'b0, cfg.moment_limit});
        if (hold1_reg)
        begin
            mom_next = '0;
        end
        else if (mdiff_sh > mlim)
        begin
            mom_next = mlim[16:0];
        end
        else if (mdiff_sh < -mlim)
        begin
            mom_next = 17'(-mlim);
        end
        else
        begin
            mom_next = mdiff_sh[16:0];
        end
    end

    always_comb
    begin
        tp_next = $signed({1'b0, cfg.surge_gain}) * serr_reg;
    end

    always_comb
    begin
        tsh  = tp_reg >>> 8;
        tlim = $signed({18'b0, cfg.thrust_limit});
        if (hold4_reg)
        begin
            thr_next = '0;
        end
        else if (tsh > tlim)
        begin
            thr_next = tlim[16:0];
        end
        else if (tsh < -tlim)
        begin
            thr_next = 17'(-tlim);
        end
        else
        begin
            thr_next = tsh[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            vr_reg <= in_valid;
            v1_reg <= vr_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg   <= sat16(xsh);
            sin_reg   <= sat16(ysh);
            sdr_reg   <= side_in;

            pv_reg    <= pv_next;
            ps_reg    <= ps_next;
            pm_reg    <= pm_next;
            pd_reg    <= pd_next;
            hold1_reg <= sdr_reg.hold;

            u2_reg    <= u_next;
            mom2_reg  <= mom_next;
            hold2_reg <= hold1_reg;

            serr_reg  <= $signed({cfg.speed_target[15], cfg.speed_target})
                         - $signed({u2_reg[15], u2_reg});
            u3_reg    <= u2_reg;
            mom3_reg  <= mom2_reg;
            hold3_reg <= hold2_reg;

            tp_reg    <= tp_next;
            u4_reg    <= u3_reg;
            mom4_reg  <= mom3_reg;
            hold4_reg <= hold3_reg;

            thr_reg   <= thr_next;
            mom5_reg  <= mom4_reg;
            u5_reg    <= u4_reg;
            hold5_reg <= hold4_reg;
        end
    end

    assign out_valid     = v5_reg;
    assign thrust        = thr_reg;
    assign turn_moment   = mom5_reg;
    assign forward_speed = u5_reg;
    assign holding       = hold5_reg;

endmodule

/* rtl/speed_heading_controller.sv */
// Throughput: one item per cycle unless the output stalls;
// the rotation runs as one register stage per CORDIC step.
// A stall on a valid output freezes every stage at once, so nothing is lost or repeated.
// Reset clears all stage valid bits and loads the control registers with their defaults;
// items are accepted from the first cycle after reset.
module speed_heading_controller
    import shc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  vel_forward_axis,
    input  logic signed [15:0]  vel_lateral_axis,
    input  logic signed [15:0]  heading,
    input  logic signed [15:0]  yaw_rate,
    input  logic [31:0]         elapsed_ms,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [16:0]  thrust,
    output logic signed [16:0]  turn_moment,
    output logic signed [15:0]  forward_speed,
    output logic                holding
);

    logic signed [15:0]   speed_target_reg;
    logic signed [15:0]   heading_target_reg;
    logic [15:0]          surge_gain_reg;
    logic [15:0]          thrust_limit_reg;
    logic [15:0]          yaw_prop_gain_reg;
    logic [15:0]          yaw_damp_gain_reg;
    logic [15:0]          moment_limit_reg;
    logic [31:0]          hold_time_ms_reg;

    logic                 en;
    side_t                side_in;
    logic                 red_valid;
    logic signed [ZW-1:0] red_z;
    side_t                red_side;
    logic                 cor_valid;
    logic signed [XW-1:0] cor_x;
    logic signed [XW-1:0] cor_y;
    side_t                cor_side;
    law_cfg_t             law_cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_target_reg   <= 16'sd1280;
            heading_target_reg <= 16'sd1072;
            surge_gain_reg     <= 16'd3000;
            thrust_limit_reg   <= 16'd20000;
            yaw_prop_gain_reg  <= 16'd125;
            yaw_damp_gain_reg  <= 16'd500;
            moment_limit_reg   <= 16'd5000;
            hold_time_ms_reg   <= 32'd2000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPEED_TARGET:   speed_target_reg   <= cfg_data[15:0];
                REG_HEADING_TARGET: heading_target_reg <= cfg_data[15:0];
                REG_SURGE_GAIN:     surge_gain_reg     <= cfg_data[15:0];
                REG_THRUST_LIMIT:   thrust_limit_reg   <= cfg_data[15:0];
                REG_YAW_PROP_GAIN:  yaw_prop_gain_reg  <= cfg_data[15:0];
                REG_YAW_DAMP_GAIN:  yaw_damp_gain_reg  <= cfg_data[15:0];
                REG_MOMENT_LIMIT:   moment_limit_reg   <= cfg_data[15:0];
                REG_HOLD_TIME_MS:   hold_time_ms_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // The whole pipeline advances unless a finished item is waiting to be taken.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        side_in.vx   = vel_forward_axis;
        side_in.vl   = vel_lateral_axis;
        side_in.rate = yaw_rate;
        side_in.herr = $signed({heading_target_reg[15], heading_target_reg})
                       - $signed({heading[15], heading});
        side_in.hold = elapsed_ms < hold_time_ms_reg;
        side_in.neg  = 1'b0;
    end

    always_comb
    begin
        law_cfg.speed_target  = speed_target_reg;
        law_cfg.surge_gain    = surge_gain_reg;
        law_cfg.thrust_limit  = thrust_limit_reg;
        law_cfg.yaw_prop_gain = yaw_prop_gain_reg;
        law_cfg.yaw_damp_gain = yaw_damp_gain_reg;
        law_cfg.moment_limit  = moment_limit_reg;
    end

    shc_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .heading   (heading),
        .side_in   (side_in),
        .out_valid (red_valid),
        .z_out     (red_z),
        .side_out  (red_side)
    );

    shc_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (red_valid),
        .z_in      (red_z),
        .side_in   (red_side),
        .out_valid (cor_valid),
        .x_out     (cor_x),
        .y_out     (cor_y),
        .side_out  (cor_side)
    );

    shc_law u_law (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (cor_valid),
        .x_in          (cor_x),
        .y_in          (cor_y),
        .side_in       (cor_side),
        .cfg           (law_cfg),
        .out_valid     (out_valid),
        .thrust        (thrust),
        .turn_moment   (turn_moment),
        .forward_speed (forward_speed),
        .holding       (holding)
    );

`ifndef SYNTHESIS
    // During the float phase both actuator outputs are forced to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && holding |-> thrust == '0 && turn_moment == '0)
        else $error("nonzero actuation while holding");

    // Clamping to a 16-bit magnitude can never yield the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> thrust != {1'b1, 16'b0} && turn_moment != {1'b1, 16'b0})
        else $error("clamp produced an out-of-range result");

    // A held output stage must stay valid in the next cycle, with the input stall following the output stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && in_stall == out_stall)
        else $error("pipeline advanced while the output was held");
`endif

endmodule
